FILE: rtl/bse_pkg.sv
// Shared constants for the bytecode stack engine: field widths, opcodes and status codes.
package bse_pkg;

    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;

    localparam int DEFAULT_STACK_DEPTH = 32;

    // Opcodes carried in the input tuser field
    localparam logic [KIND_W-1:0] OP_PUSH = 3'd0;
    localparam logic [KIND_W-1:0] OP_DUMP = 3'd1;
    localparam logic [KIND_W-1:0] OP_PEEK = 3'd2;
    localparam logic [KIND_W-1:0] OP_POP  = 3'd3;
    localparam logic [KIND_W-1:0] OP_SWAP = 3'd4;

    // Result status codes carried in the output tuser field
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PEEK_EMPTY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SWAP_SHORT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 3'd4;

endpackage

FILE: rtl/bse_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/bytecode_stack_engine_core.sv
// Bytecode stack engine: bounded LIFO of signed 32-bit words driven by opcodes.
//
// Input channel (s_axis): one beat per opcode. tuser holds the opcode
// (push, dump, peek, pop, swap), tdata the operand used by push.
// Output channel (m_axis): tdata holds a stack entry (zero on error), tuser the
// status code, tlast marks the final result beat of one opcode.
// Results per opcode, all sequenced around the one-read, one-write entry RAM:
//   push, pop, undefined opcodes: no result.
//   peek: one result beat, read from the RAM and then registered for output.
//   errors: one result beat with the error status.
//   swap: two reads, two writes, no result.
//   dump of N entries: N result beats from the top down, one per cycle after
//   the first RAM read while the receiver keeps up; an empty dump gives nothing.
// A one-beat output register parts the two channels, so a finished result may
// wait while the next opcode is taken. A stalled receiver holds the result
// register; a peek, dump or error then pauses until the beat is taken.
// Reset clears the fill count and all control state; the entry RAM needs no
// clearing since only entries below the fill count are ever read.
module bytecode_stack_engine_core
    import bse_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [DATA_W-1:0]   s_axis_tdata,   // [31:0] operand
    input  logic [KIND_W-1:0]   s_axis_tuser,   // [2:0] kind
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [DATA_W-1:0]   m_axis_tdata,   // [31:0] value
    output logic [STATUS_W-1:0] m_axis_tuser,   // [2:0] status
    output logic                m_axis_tlast
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_EMIT       = 3'd1;
    localparam logic [2:0] S_ERR        = 3'd2;
    localparam logic [2:0] S_SWAP_RD    = 3'd3;
    localparam logic [2:0] S_SWAP_WRTOP = 3'd4;
    localparam logic [2:0] S_SWAP_WRLOW = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                peek_reg, peek_next;
    logic [DATA_W-1:0]   swap_top_reg, swap_top_next;
    logic [STATUS_W-1:0] err_reg, err_next;

    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_value_reg, out_value_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;

    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [DATA_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [DATA_W-1:0]   ram_rd_data;

    logic [CNT_W-1:0]    count_dec1;
    logic [CNT_W-1:0]    count_dec2;
    logic                is_empty;
    logic                is_full;
    logic                slot_free;
    logic                emit_last;

    bse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_entries (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign count_dec1 = count_reg - CNT_W'(1);
    assign count_dec2 = count_reg - CNT_W'(2);
    assign is_empty   = (count_reg == '0);
    assign is_full    = (count_reg == CNT_W'(STACK_DEPTH));
    assign slot_free  = !out_valid_reg || m_axis_tready;
    assign emit_last  = peek_reg || (addr_reg == '0);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    // Sequencer: decode opcodes, drive the RAM, load result beats
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        addr_next       = addr_reg;
        peek_next       = peek_reg;
        swap_top_next   = swap_top_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = count_reg[ADDR_W-1:0];
        ram_wr_data     = s_axis_tdata;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = count_dec1[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    case (s_axis_tuser)
                        OP_PUSH:
                        begin
                            if (is_full)
                            begin
                                err_next   = ST_PUSH_FULL;
                                state_next = S_ERR;
                            end
                            else
                            begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DUMP:
                        begin
                            if (!is_empty)
                            begin
                                ram_rd_en  = 1'b1;
                                addr_next  = count_dec1[ADDR_W-1:0];
                                peek_next  = 1'b0;
                                state_next = S_EMIT;
                            end
                        end
                        OP_PEEK:
                        begin
                            if (is_empty)
                            begin
                                err_next   = ST_PEEK_EMPTY;
                                state_next = S_ERR;
                            end
                            else
                            begin
                                ram_rd_en  = 1'b1;
                                addr_next  = count_dec1[ADDR_W-1:0];
                                peek_next  = 1'b1;
                                state_next = S_EMIT;
                            end
                        end
                        OP_POP:
                        begin
                            if (is_empty)
                            begin
                                err_next   = ST_POP_EMPTY;
                                state_next = S_ERR;
                            end
                            else
                            begin
                                count_next = count_dec1;
                            end
                        end
                        OP_SWAP:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                err_next   = ST_SWAP_SHORT;
                                state_next = S_ERR;
                            end
                            else
                            begin
                                ram_rd_en  = 1'b1;
                                state_next = S_SWAP_RD;
                            end
                        end
                        default:
                        begin
                            // Drop undefined opcodes
                        end
                    endcase
                end
            end

            S_EMIT:
            begin
                // Emit the entry just read and, unless it is the last, fetch the one below it
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = ram_rd_data;
                    out_status_next = ST_OK;
                    out_last_next   = emit_last;
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        addr_next   = addr_reg - ADDR_W'(1);
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = addr_reg - ADDR_W'(1);
                    end
                end
            end

            S_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_status_next = err_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_SWAP_RD:
            begin
                // Hold the top entry, read the one below
                swap_top_next = ram_rd_data;
                ram_rd_en     = 1'b1;
                ram_rd_addr   = count_dec2[ADDR_W-1:0];
                state_next    = S_SWAP_WRTOP;
            end

            S_SWAP_WRTOP:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = count_dec1[ADDR_W-1:0];
                ram_wr_data = ram_rd_data;
                state_next  = S_SWAP_WRLOW;
            end

            S_SWAP_WRLOW:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = count_dec2[ADDR_W-1:0];
                ram_wr_data = swap_top_reg;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        peek_reg       <= peek_next;
        swap_top_reg   <= swap_top_next;
        err_reg        <= err_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

endmodule
